### rtl/core/tass_pkg.sv
`default_nettype none

package tass_pkg;

  // Default coordinate width of the waypoint fields
  localparam int unsigned COORD_BITS_DEF = 16;

  // Register port geometry
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  // Fixed field widths
  localparam int unsigned COS_W    = 16;
  localparam int unsigned COS_FRAC = 15;
  localparam int unsigned COS_SQ_W = 31;
  localparam int unsigned SCALE_W  = 17;

  // Multiplier limb width and latency
  localparam int unsigned LIMB_W      = 32;
  localparam int unsigned MUL_LATENCY = 3;

  localparam logic [SCALE_W-1:0] FULL_SCALE = 17'h10000;

  // Register reset values
  localparam logic                 RST_ENABLED     = 1'b1;
  localparam logic [COS_W-1:0]     RST_COS_MILD    = 16'd27969;
  localparam logic [COS_W-1:0]     RST_COS_SHARP   = 16'd0;
  localparam logic [SCALE_W-1:0]   RST_MILD_SCALE  = 17'd45875;
  localparam logic [SCALE_W-1:0]   RST_SHARP_SCALE = 17'd19661;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CFG  = 2'd1,
    STATUS_ZERO_SEG = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_ENABLED     = 3'd0,
    REG_COS_MILD    = 3'd1,
    REG_COS_SHARP   = 3'd2,
    REG_MILD_SCALE  = 3'd3,
    REG_SHARP_SCALE = 3'd4
  } reg_e;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic                 enabled;
    logic [COS_W-1:0]     cos_mild;
    logic [COS_W-1:0]     cos_sharp;
    logic [SCALE_W-1:0]   mild_scale;
    logic [SCALE_W-1:0]   sharp_scale;
    logic                 bad;
    logic [COS_SQ_W-1:0]  cos_mild_sq;
    logic [COS_SQ_W-1:0]  cos_sharp_sq;
  } cfg_t;

  // Per-request side information carried down the pipeline
  typedef struct packed {
    logic               done;
    logic [SCALE_W-1:0] scale;
    status_e            status;
    logic               dot_neg;
  } tag_t;

endpackage

`default_nettype wire

### rtl/core/tass_in_if.sv
`default_nettype none

interface tass_in_if #(
  parameter int unsigned COORD_BITS = tass_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic signed [COORD_BITS-1:0] prev_z;
  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic signed [COORD_BITS-1:0] cur_z;
  logic signed [COORD_BITS-1:0] next_x;
  logic signed [COORD_BITS-1:0] next_y;
  logic signed [COORD_BITS-1:0] next_z;
  logic                         next_present;

  modport source (
    output valid, prev_x, prev_y, prev_z, cur_x, cur_y, cur_z,
           next_x, next_y, next_z, next_present,
    input  ready
  );

  modport sink (
    input  valid, prev_x, prev_y, prev_z, cur_x, cur_y, cur_z,
           next_x, next_y, next_z, next_present,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/tass_out_if.sv
`default_nettype none

interface tass_out_if;
  logic                         valid;
  logic                         ready;
  logic [tass_pkg::SCALE_W-1:0] speed_scale;
  logic [1:0]                   status;

  modport source (output valid, speed_scale, status, input ready);
  modport sink (input valid, speed_scale, status, output ready);
endinterface

`default_nettype wire

### rtl/core/turn_angle_speed_scale.sv
// Turn-angle speed scaler.
// Input channel in_i carries three waypoints (previous, current, next) and a
// next_present flag; output channel out_o returns one speed scale (Q1.16,
// 65536 = 1.0) and a status per request, in request order. Both channels use
// valid/ready; a request moves on a clock edge with valid and ready high.
// Thresholds and scales are set through the APB register port; the user is
// to write them only while the block is idle, as the block does not enforce
// it. Registers sit at byte addresses 0, 4, 8, 12 and 16. A request passes
// eleven register stages, the first loaded by the edge that accepts it: four
// front-end stages (differences, products, sums, magnitude), two layers of
// 3-stage limb multipliers in series (squared dot and squared lengths, then
// threshold scaling) and the output register.
// Throughput: one request per cycle. Every stage has its own valid bit and
// loads whenever it is empty or the stage after it moves, so a stalled
// receiver only stops input once all stages are full; nothing is dropped or
// duplicated.
// Reset clears all valid bits and loads the register reset values; the
// output is not valid again until a request has gone through.
`default_nettype none

module turn_angle_speed_scale #(
  parameter int unsigned COORD_BITS = tass_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tass_in_if.sink                          in_i,
  tass_out_if.source                       out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tass_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tass_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tass_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int unsigned DW     = 2 * COORD_BITS + 2;
  localparam int unsigned YW     = 2 * DW;
  localparam int unsigned ZW     = YW + tass_pkg::COS_SQ_W;
  localparam int unsigned ML     = tass_pkg::MUL_LATENCY;
  localparam int unsigned NSTAGE = 4 + 2 * ML + 1;
  localparam int unsigned XY_S   = 4;
  localparam int unsigned Z_S    = XY_S + ML;
  localparam int unsigned NTAG   = 2 * ML;
  localparam int unsigned SW     = tass_pkg::SCALE_W;
  localparam int unsigned CW     = tass_pkg::COS_W;

  tass_pkg::cfg_t   cfg;
  logic [NSTAGE-1:0] vld_q, vld_d, vld_in, en;

  logic signed [COORD_BITS-1:0] prev_c [3];
  logic signed [COORD_BITS-1:0] cur_c [3];
  logic signed [COORD_BITS-1:0] next_c [3];

  logic [DW-1:0]     dot_mag, na2, nb2;
  tass_pkg::tag_t    geom_tag;
  logic [YW-1:0]     x_prod, y_prod;
  logic [ZW-1:0]     zs_prod, zm_prod;
  logic [YW-1:0]     x_q [ML];
  tass_pkg::tag_t    tag_q [NTAG];

  logic [ZW-1:0]     lsq;
  logic              sharp_hit, mild_hit;
  logic [SW-1:0]     scale_d, scale_q;
  tass_pkg::status_e status_d, status_q;

  // Register file
  tass_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en[NSTAGE-1] = !vld_q[NSTAGE-1] || out_o.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) en[k] = !vld_q[k] || en[k+1];
  end

  assign vld_in     = {vld_q[NSTAGE-2:0], in_i.valid};
  assign vld_d      = (en & vld_in) | (~en & vld_q);
  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Front end
  always_comb begin
    prev_c[0] = in_i.prev_x;
    prev_c[1] = in_i.prev_y;
    prev_c[2] = in_i.prev_z;
    cur_c[0]  = in_i.cur_x;
    cur_c[1]  = in_i.cur_y;
    cur_c[2]  = in_i.cur_z;
    next_c[0] = in_i.next_x;
    next_c[1] = in_i.next_y;
    next_c[2] = in_i.next_z;
  end

  tass_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk_i          (clk_i),
    .en_i           (en[3:0]),
    .prev_i         (prev_c),
    .cur_i          (cur_c),
    .next_i         (next_c),
    .next_present_i (in_i.next_present),
    .cfg_i          (cfg),
    .dot_mag_o      (dot_mag),
    .na2_o          (na2),
    .nb2_o          (nb2),
    .tag_o          (geom_tag)
  );

  // Squared dot product and product of squared lengths
  tass_mul #(.AW(DW), .BW(DW)) u_mul_x (
    .clk_i (clk_i),
    .en_i  (en[XY_S +: ML]),
    .a_i   (dot_mag),
    .b_i   (dot_mag),
    .p_o   (x_prod)
  );

  tass_mul #(.AW(DW), .BW(DW)) u_mul_y (
    .clk_i (clk_i),
    .en_i  (en[XY_S +: ML]),
    .a_i   (na2),
    .b_i   (nb2),
    .p_o   (y_prod)
  );

  // Thresholds scaled by the squared lengths
  tass_mul #(.AW(tass_pkg::COS_SQ_W), .BW(YW)) u_mul_zs (
    .clk_i (clk_i),
    .en_i  (en[Z_S +: ML]),
    .a_i   (cfg.cos_sharp_sq),
    .b_i   (y_prod),
    .p_o   (zs_prod)
  );

  tass_mul #(.AW(tass_pkg::COS_SQ_W), .BW(YW)) u_mul_zm (
    .clk_i (clk_i),
    .en_i  (en[Z_S +: ML]),
    .a_i   (cfg.cos_mild_sq),
    .b_i   (y_prod),
    .p_o   (zm_prod)
  );

  // Side information and squared dot travel alongside the multipliers
  always_ff @(posedge clk_i) begin
    if (en[XY_S]) tag_q[0] <= geom_tag;
    for (int s = 1; s < NTAG; s++) begin
      if (en[XY_S+s]) tag_q[s] <= tag_q[s-1];
    end
    if (en[Z_S]) x_q[0] <= x_prod;
    for (int s = 1; s < ML; s++) begin
      if (en[Z_S+s]) x_q[s] <= x_q[s-1];
    end
  end

  // cos <= c decided from squares and signs
  function automatic logic cos_at_most(input logic          dot_neg,
                                       input logic          c_neg,
                                       input logic [ZW-1:0] l,
                                       input logic [ZW-1:0] r);
    logic res;
    if (dot_neg) res = c_neg ? (l >= r) : 1'b1;
    else         res = c_neg ? 1'b0 : (l <= r);
    return res;
  endfunction

  // Classification and output register
  always_comb begin
    lsq       = ZW'(x_q[ML-1]) << (2 * tass_pkg::COS_FRAC);
    sharp_hit = cos_at_most(tag_q[NTAG-1].dot_neg, cfg.cos_sharp[CW-1], lsq, zs_prod);
    mild_hit  = cos_at_most(tag_q[NTAG-1].dot_neg, cfg.cos_mild[CW-1], lsq, zm_prod);
    status_d  = tag_q[NTAG-1].status;
    if (tag_q[NTAG-1].done) scale_d = tag_q[NTAG-1].scale;
    else if (sharp_hit)     scale_d = cfg.sharp_scale;
    else if (mild_hit)      scale_d = cfg.mild_scale;
    else                    scale_d = tass_pkg::FULL_SCALE;
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTAGE-1]) begin
      scale_q  <= scale_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid       = vld_q[NSTAGE-1];
  assign out_o.speed_scale = scale_q;
  assign out_o.status      = status_q;

endmodule

`default_nettype wire

### rtl/core/tass_cfg.sv
`default_nettype none

module tass_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tass_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [tass_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [tass_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output tass_pkg::cfg_t                    cfg_o
);

  localparam int unsigned CW = tass_pkg::COS_W;
  localparam int unsigned SW = tass_pkg::SCALE_W;
  localparam int unsigned QW = tass_pkg::COS_SQ_W;
  localparam int unsigned DW = tass_pkg::APB_DATA_W;

  logic          enabled_q;
  logic [CW-1:0] cos_mild_q;
  logic [CW-1:0] cos_sharp_q;
  logic [SW-1:0] mild_scale_q;
  logic [SW-1:0] sharp_scale_q;
  logic [QW-1:0] mild_sq_q, mild_sq_d;
  logic [QW-1:0] sharp_sq_q, sharp_sq_d;
  logic [CW-1:0] mild_mag, sharp_mag;
  logic          wr_en;
  tass_pkg::reg_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = tass_pkg::reg_e'(paddr[tass_pkg::APB_ADDR_W-1:2]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q     <= tass_pkg::RST_ENABLED;
      cos_mild_q    <= tass_pkg::RST_COS_MILD;
      cos_sharp_q   <= tass_pkg::RST_COS_SHARP;
      mild_scale_q  <= tass_pkg::RST_MILD_SCALE;
      sharp_scale_q <= tass_pkg::RST_SHARP_SCALE;
    end else if (wr_en) begin
      case (idx)
        tass_pkg::REG_ENABLED:     enabled_q     <= pwdata[0];
        tass_pkg::REG_COS_MILD:    cos_mild_q    <= pwdata[CW-1:0];
        tass_pkg::REG_COS_SHARP:   cos_sharp_q   <= pwdata[CW-1:0];
        tass_pkg::REG_MILD_SCALE:  mild_scale_q  <= pwdata[SW-1:0];
        tass_pkg::REG_SHARP_SCALE: sharp_scale_q <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      tass_pkg::REG_ENABLED:     prdata = DW'(enabled_q);
      tass_pkg::REG_COS_MILD:    prdata = DW'(cos_mild_q);
      tass_pkg::REG_COS_SHARP:   prdata = DW'(cos_sharp_q);
      tass_pkg::REG_MILD_SCALE:  prdata = DW'(mild_scale_q);
      tass_pkg::REG_SHARP_SCALE: prdata = DW'(sharp_scale_q);
      default:                   prdata = '0;
    endcase
  end

  // Squared threshold magnitudes, used deep in the pipeline
  always_comb begin
    mild_mag   = cos_mild_q[CW-1]  ? CW'(-cos_mild_q)  : cos_mild_q;
    sharp_mag  = cos_sharp_q[CW-1] ? CW'(-cos_sharp_q) : cos_sharp_q;
    mild_sq_d  = QW'(32'(mild_mag) * 32'(mild_mag));
    sharp_sq_d = QW'(32'(sharp_mag) * 32'(sharp_mag));
  end

  always_ff @(posedge clk_i) begin
    mild_sq_q  <= mild_sq_d;
    sharp_sq_q <= sharp_sq_d;
  end

  // Datapath view plus the settings check
  always_comb begin
    cfg_o.enabled      = enabled_q;
    cfg_o.cos_mild     = cos_mild_q;
    cfg_o.cos_sharp    = cos_sharp_q;
    cfg_o.mild_scale   = mild_scale_q;
    cfg_o.sharp_scale  = sharp_scale_q;
    cfg_o.cos_mild_sq  = mild_sq_q;
    cfg_o.cos_sharp_sq = sharp_sq_q;
    cfg_o.bad          = ($signed(cos_sharp_q) >= $signed(cos_mild_q)) ||
                         (cos_sharp_q == {1'b1, {(CW-1){1'b0}}}) ||
                         (sharp_scale_q == '0) ||
                         (mild_scale_q <= sharp_scale_q) ||
                         (mild_scale_q > tass_pkg::FULL_SCALE);
  end

endmodule

`default_nettype wire

### rtl/core/tass_mul.sv
`default_nettype none

// Pipelined unsigned multiplier built from 32x32 limb products.
// Stage 1: limb products, stage 2: row sums, stage 3: sum of rows.
module tass_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  logic                              clk_i,
  input  logic [tass_pkg::MUL_LATENCY-1:0]  en_i,
  input  logic [AW-1:0]                     a_i,
  input  logic [BW-1:0]                     b_i,
  output logic [AW+BW-1:0]                  p_o
);

  localparam int unsigned LW = tass_pkg::LIMB_W;
  localparam int unsigned NA = (AW + LW - 1) / LW;
  localparam int unsigned NB = (BW + LW - 1) / LW;
  localparam int unsigned RW = (NB + 1) * LW;
  localparam int unsigned TW = (NA + NB) * LW;
  localparam int unsigned PW = AW + BW;

  logic [NA*LW-1:0] a_ext;
  logic [NB*LW-1:0] b_ext;
  logic [2*LW-1:0]  pp_q [NA][NB];
  logic [RW-1:0]    row_d [NA];
  logic [RW-1:0]    row_q [NA];
  logic [TW-1:0]    sum_d;
  logic [PW-1:0]    p_q;

  assign a_ext = (NA*LW)'(a_i);
  assign b_ext = (NB*LW)'(b_i);

  // Limb products
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= a_ext[i*LW +: LW] * b_ext[j*LW +: LW];
        end
      end
    end
  end

  // Row sums: even and odd limb products do not overlap, so one add per row
  always_comb begin
    logic [RW-1:0] ev;
    logic [RW-1:0] od;
    for (int i = 0; i < NA; i++) begin
      ev = '0;
      od = '0;
      for (int j = 0; j < NB; j++) begin
        if (j[0]) od[j*LW +: 2*LW] = pp_q[i][j];
        else      ev[j*LW +: 2*LW] = pp_q[i][j];
      end
      row_d[i] = ev + od;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int i = 0; i < NA; i++) row_q[i] <= row_d[i];
    end
  end

  // Sum of the shifted rows
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) sum_d = sum_d + (TW'(row_q[i]) << (i*LW));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) p_q <= PW'(sum_d);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

### rtl/core/tass_geom.sv
`default_nettype none

// Front end: segment vectors, early outcomes, dot product and squared lengths.
module tass_geom #(
  parameter int unsigned COORD_BITS = tass_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic [3:0]                    en_i,
  input  logic signed [COORD_BITS-1:0]  prev_i [3],
  input  logic signed [COORD_BITS-1:0]  cur_i [3],
  input  logic signed [COORD_BITS-1:0]  next_i [3],
  input  logic                          next_present_i,
  input  tass_pkg::cfg_t                cfg_i,
  output logic [2*COORD_BITS+1:0]       dot_mag_o,
  output logic [2*COORD_BITS+1:0]       na2_o,
  output logic [2*COORD_BITS+1:0]       nb2_o,
  output tass_pkg::tag_t                tag_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned VW = CB + 1;
  localparam int unsigned PW = 2 * CB + 2;
  localparam int unsigned DW = 2 * CB + 2;

  logic signed [VW-1:0] a_d [3];
  logic signed [VW-1:0] b_d [3];
  logic signed [VW-1:0] a_q [3];
  logic signed [VW-1:0] b_q [3];
  logic signed [PW-1:0] sqa_q [3];
  logic signed [PW-1:0] sqb_q [3];
  logic signed [PW-1:0] ab_q [3];
  logic [DW-1:0]        na2_d, nb2_d, na2_q, nb2_q, na2_4q, nb2_4q;
  logic signed [DW:0]   dot_d, dot_q;
  logic [DW-1:0]        mag_d, mag_q;
  logic                 a_zero, b_zero;
  tass_pkg::tag_t       tag1_d, tag1_q, tag2_q, tag3_q, tag4_d, tag4_q;

  // Stage 1: segment vectors and early outcomes
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_d[k] = VW'(cur_i[k]) - VW'(prev_i[k]);
      b_d[k] = VW'(next_i[k]) - VW'(cur_i[k]);
    end
    a_zero = (a_d[0] == '0) && (a_d[1] == '0) && (a_d[2] == '0);
    b_zero = (b_d[0] == '0) && (b_d[1] == '0) && (b_d[2] == '0);

    tag1_d.done    = 1'b0;
    tag1_d.scale   = tass_pkg::FULL_SCALE;
    tag1_d.status  = tass_pkg::STATUS_OK;
    tag1_d.dot_neg = 1'b0;
    if (!cfg_i.enabled || !next_present_i) begin
      tag1_d.done = 1'b1;
    end else if (cfg_i.bad) begin
      tag1_d.done   = 1'b1;
      tag1_d.scale  = '0;
      tag1_d.status = tass_pkg::STATUS_BAD_CFG;
    end else if (a_zero || b_zero) begin
      tag1_d.done   = 1'b1;
      tag1_d.scale  = '0;
      tag1_d.status = tass_pkg::STATUS_ZERO_SEG;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q    <= a_d;
      b_q    <= b_d;
      tag1_q <= tag1_d;
    end
  end

  // Stage 2: component products
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int k = 0; k < 3; k++) begin
        sqa_q[k] <= a_q[k] * a_q[k];
        sqb_q[k] <= b_q[k] * b_q[k];
        ab_q[k]  <= a_q[k] * b_q[k];
      end
      tag2_q <= tag1_q;
    end
  end

  // Stage 3: squared lengths and signed dot product
  always_comb begin
    na2_d = DW'($unsigned(sqa_q[0])) + DW'($unsigned(sqa_q[1])) +
            DW'($unsigned(sqa_q[2]));
    nb2_d = DW'($unsigned(sqb_q[0])) + DW'($unsigned(sqb_q[1])) +
            DW'($unsigned(sqb_q[2]));
    dot_d = (DW+1)'(ab_q[0]) + (DW+1)'(ab_q[1]) + (DW+1)'(ab_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      na2_q  <= na2_d;
      nb2_q  <= nb2_d;
      dot_q  <= dot_d;
      tag3_q <= tag2_q;
    end
  end

  // Stage 4: dot magnitude and sign
  always_comb begin
    mag_d          = dot_q[DW] ? DW'(-dot_q) : DW'(dot_q);
    tag4_d         = tag3_q;
    tag4_d.dot_neg = dot_q[DW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      mag_q  <= mag_d;
      na2_4q <= na2_q;
      nb2_4q <= nb2_q;
      tag4_q <= tag4_d;
    end
  end

  assign dot_mag_o = mag_q;
  assign na2_o     = na2_4q;
  assign nb2_o     = nb2_4q;
  assign tag_o     = tag4_q;

endmodule

`default_nettype wire
